/* src/ica_pkg.sv */
package ica_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_DECIDE,
    ST_ADD_RD,
    ST_ADD_WR
  } ica_state_t;

  localparam logic [7:0] CAPACITY_RESET = 8'd1;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

/* src/ica_ram.sv */
module ica_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/interval_capacity_admission.sv */
// Interval admission against a per-slot capacity. Occupancy is held one entry
// per slot in a single-port-write, registered-read memory worked by one
// sequencer. After reset the occupancy memory is cleared, with busy high. A
// request with an empty range is admitted from idle, with out_valid in the
// cycle after start. Otherwise the maximum is scanned at one slot per cycle,
// and an admitted request then increments each slot with a read-modify-write
// (read in ST_ADD_RD, write in ST_ADD_WR). The result strobe out_valid is high
// for one cycle per request and must be taken then: the receiver cannot stall.
module interval_capacity_admission
  import ica_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_start_slot,
  input  logic [10:0] in_end_slot,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic        out_accepted,
  output logic [31:0] out_accepted_count
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW = SW + 1;
  localparam int EW = (AW > 11) ? AW : 11;
  localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);
  localparam logic [AW-1:0] LAST_A = AW'(SLOTS - 1);

  ica_state_t       state_r, state_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    lo_r, lo_nxt;
  logic [AW-1:0]    end_r, end_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [7:0]       peak_r, peak_nxt;
  logic [7:0]       cap_r;
  logic [31:0]      count_r, count_nxt;
  logic             ov_r, ov_nxt;
  logic             acc_r, acc_nxt;

  logic             we;
  logic [SW-1:0]    waddr, raddr;
  logic [7:0]       wdata, rdata;
  logic [EW-1:0]    s_e, e_e, e_cl;
  logic [31:0]      count_inc;

  ica_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_occ (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign s_e = EW'(in_start_slot);
  assign e_e = EW'(in_end_slot);
  assign e_cl = (e_e > SLOTS_E) ? SLOTS_E : e_e;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      rd_vld_r <= 1'b0;
      count_r <= '0;
      ov_r    <= 1'b0;
      cap_r   <= CAPACITY_RESET;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    end_r  <= end_nxt;
    peak_r <= peak_nxt;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    lo_nxt     = lo_r;
    end_nxt    = end_r;
    rd_vld_nxt = 1'b0;
    peak_nxt   = peak_r;
    count_nxt  = count_r;
    ov_nxt     = 1'b0;
    acc_nxt    = acc_r;
    we         = 1'b0;
    waddr      = ptr_r[SW-1:0];
    wdata      = rdata + 8'd1;
    raddr      = ptr_r[SW-1:0];
    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (s_e >= e_cl) begin
            ov_nxt    = 1'b1;
            acc_nxt   = 1'b1;
            count_nxt = count_inc;
          end else begin
            lo_nxt    = AW'(s_e);
            ptr_nxt   = AW'(s_e);
            end_nxt   = AW'(e_cl);
            peak_nxt  = '0;
            state_nxt = ST_QUERY;
          end
        end
      end
      ST_QUERY: begin
        if (rd_vld_r && rdata > peak_r) begin
          peak_nxt = rdata;
        end
        if (ptr_r != end_r) begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + AW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ptr_nxt = lo_r;
        if (peak_r < cap_r) begin
          state_nxt = ST_ADD_RD;
        end else begin
          ov_nxt    = 1'b1;
          acc_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD_RD: begin
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        we      = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_nxt == end_r) begin
          ov_nxt    = 1'b1;
          acc_nxt   = 1'b1;
          count_nxt = count_inc;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ADD_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = ov_r;
  assign out_accepted       = acc_r;
  assign out_accepted_count = count_r;

endmodule
